// ===== rtl/lgge_pkg.sv =====
`timescale 1ns / 1ps

package lgge_pkg;

    // Grid size
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 512;

    // Index widths into the grid
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    // Widths that can hold the full count
    localparam int COLS_CNT_W = $clog2(MAX_COLS + 1);
    localparam int ROWS_CNT_W = $clog2(MAX_ROWS + 1);

    // Item field widths
    localparam int FUNC_FW = 2;
    localparam int COL_FW  = 10;
    localparam int ROW_FW  = 9;

    // Config register widths
    localparam int BOARD_COLS_W = 11;
    localparam int BOARD_ROWS_W = 10;

    // Config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_BOARD_COLS = 1'b0;
    localparam logic REG_BOARD_ROWS = 1'b1;

    // Operation codes
    localparam logic [FUNC_FW-1:0] FUNC_TOGGLE  = 2'd0;
    localparam logic [FUNC_FW-1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [FUNC_FW-1:0] FUNC_READ    = 2'd2;
    // Spare code, treated as a no-op
    localparam logic [FUNC_FW-1:0] FUNC_UNUSED  = 2'd3;

    typedef struct packed {
        logic [FUNC_FW-1:0] func;
        logic [COL_FW-1:0]  col;
        logic [ROW_FW-1:0]  row;
    } cmd_t;

    typedef struct packed {
        logic cell_alive;
        logic out_of_range;
    } rsp_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic clear_wr;
        logic rmw_rd;
        logic rmw_upd;
        logic adv_p0;
        logic adv_p1;
        logic adv_row;
        logic finish;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic go_rmw;
        logic go_adv;
        logic clear_last;
        logic last_row;
    } dp_status_t;

endpackage

// ===== rtl/life_grid_generation_engine.sv =====
`timescale 1ns / 1ps

// Bounded B3/S23 life grid. Commands: toggle a cell, advance one
// generation, or read a cell. Each accepted item gives exactly one result,
// shown on rsp for a single cycle with done high; there is no stall on the
// result side, so the receiver must take it in that cycle. Items are taken
// one at a time: start is accepted when busy is low. Toggle and read go
// through a row read, a modify and write back, then a finish state. An
// advance sweeps the clamped board height: the grid memory holds one full
// row per word and the sweep updates one row per cycle on its single read
// and single write port. Out-of-range addresses, an empty board and the
// unused operation code go straight to the finish state. After reset the
// block runs a clearing pass over all MAX_ROWS (512) rows with busy high;
// configuration writes are taken during it.

module life_grid_generation_engine
    import lgge_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               start,
    output logic               busy,
    input  cmd_t               cmd,
    // result channel
    output logic               done,
    output rsp_t               rsp,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [COLS_CNT_W-1:0] cols_eff;
    logic [ROWS_CNT_W-1:0] rows_eff;
    dp_cmd_t               dp_cmd;
    dp_status_t            dp_status;

    // Board size registers, clamped to the grid
    lgge_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cols_eff (cols_eff),
        .rows_eff (rows_eff)
    );

    // Sequencer: clearing pass, cell access, generation sweep
    lgge_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .dp_cmd (dp_cmd),
        .busy   (busy)
    );

    // Grid memory, row window, next-generation logic and result registers
    lgge_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .dp_cmd   (dp_cmd),
        .cols_eff (cols_eff),
        .rows_eff (rows_eff),
        .status   (dp_status),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

// ===== rtl/lgge_cfg.sv =====
`timescale 1ns / 1ps

module lgge_cfg
    import lgge_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    output logic [COLS_CNT_W-1:0] cols_eff,
    output logic [ROWS_CNT_W-1:0] rows_eff
);

    logic [BOARD_COLS_W-1:0] board_cols_reg;
    logic [BOARD_ROWS_W-1:0] board_rows_reg;
    logic                    reg_sel;
    logic                    wr_en;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_cols_reg <= BOARD_COLS_W'(800);
            board_rows_reg <= BOARD_ROWS_W'(400);
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_BOARD_COLS: board_cols_reg <= pwdata[BOARD_COLS_W-1:0];
                REG_BOARD_ROWS: board_rows_reg <= pwdata[BOARD_ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BOARD_COLS: prdata = PDATA_W'(board_cols_reg);
            REG_BOARD_ROWS: prdata = PDATA_W'(board_rows_reg);
            default:        prdata = '0;
        endcase
    end

    // Oversized board clamps to the grid
    assign cols_eff = (32'(board_cols_reg) > MAX_COLS) ? COLS_CNT_W'(MAX_COLS)
                                                       : COLS_CNT_W'(board_cols_reg);
    assign rows_eff = (32'(board_rows_reg) > MAX_ROWS) ? ROWS_CNT_W'(MAX_ROWS)
                                                       : ROWS_CNT_W'(board_rows_reg);

endmodule

// ===== rtl/lgge_ctrl.sv =====
`timescale 1ns / 1ps

module lgge_ctrl
    import lgge_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    dp_cmd,
    output logic       busy
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_CLEAR   = 8'b0000_0010,
        ST_RMW_RD  = 8'b0000_0100,
        ST_RMW_UPD = 8'b0000_1000,
        ST_ADV_P0  = 8'b0001_0000,
        ST_ADV_P1  = 8'b0010_0000,
        ST_ADV_ROW = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Reset lands in the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.accept = 1'b1;
                    if (status.go_rmw)
                    begin
                        state_next = ST_RMW_RD;
                    end
                    else if (status.go_adv)
                    begin
                        state_next = ST_ADV_P0;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_CLEAR:
            begin
                dp_cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RMW_RD:
            begin
                dp_cmd.rmw_rd = 1'b1;
                state_next    = ST_RMW_UPD;
            end
            ST_RMW_UPD:
            begin
                dp_cmd.rmw_upd = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_ADV_P0:
            begin
                dp_cmd.adv_p0 = 1'b1;
                state_next    = ST_ADV_P1;
            end
            ST_ADV_P1:
            begin
                dp_cmd.adv_p1 = 1'b1;
                state_next    = ST_ADV_ROW;
            end
            ST_ADV_ROW:
            begin
                dp_cmd.adv_row = 1'b1;
                if (status.last_row)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                dp_cmd.finish = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/lgge_datapath.sv =====
`timescale 1ns / 1ps

module lgge_datapath
    import lgge_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  dp_cmd_t               dp_cmd,
    input  logic [COLS_CNT_W-1:0] cols_eff,
    input  logic [ROWS_CNT_W-1:0] rows_eff,
    output dp_status_t            status,
    output logic                  done,
    output rsp_t                  rsp
);

    localparam int ROW_SUM_W = ROWS_CNT_W + 1;

    // Grid: one word per row
    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_data_reg;

    // Row window for the generation sweep
    logic [MAX_COLS-1:0] above_reg;
    logic [MAX_COLS-1:0] here_reg;
    logic [MAX_COLS-1:0] mask_reg;

    cmd_t             item_reg;
    logic             alive_reg;
    logic             oor_reg;
    logic             done_reg;
    logic [ROW_W-1:0] row_cnt_reg;

    logic                 in_range;
    logic                 is_rmw_func;
    logic [ROW_SUM_W-1:0] row_p1;
    logic [ROW_SUM_W-1:0] row_p2;
    logic                 below_valid;
    logic [MAX_COLS-1:0]  below;
    logic [MAX_COLS-1:0]  next_row;
    logic [MAX_COLS-1:0]  mask_calc;
    logic [COL_W-1:0]     col_idx;
    logic                 cell_bit;
    logic                 is_toggle;

    logic                rd_en;
    logic [ROW_W-1:0]    rd_addr;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic [MAX_COLS-1:0] wr_data;

    assign is_rmw_func = (cmd.func == FUNC_TOGGLE) || (cmd.func == FUNC_READ);
    assign in_range    = (32'(cmd.col) < 32'(cols_eff)) && (32'(cmd.row) < 32'(rows_eff));

    assign row_p1      = ROW_SUM_W'(row_cnt_reg) + ROW_SUM_W'(1);
    assign row_p2      = ROW_SUM_W'(row_cnt_reg) + ROW_SUM_W'(2);
    assign below_valid = row_p1 < ROW_SUM_W'(rows_eff);
    assign below       = below_valid ? rd_data_reg : '0;

    assign status.go_rmw     = is_rmw_func && in_range;
    assign status.go_adv     = (cmd.func == FUNC_ADVANCE) && (rows_eff != '0) && (cols_eff != '0);
    assign status.clear_last = (row_cnt_reg == ROW_W'(MAX_ROWS - 1));
    assign status.last_row   = !below_valid;

    assign col_idx   = COL_W'(item_reg.col);
    assign is_toggle = (item_reg.func == FUNC_TOGGLE);
    assign cell_bit  = rd_data_reg[col_idx] ^ is_toggle;

    // Columns in use
    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            mask_calc[c] = (32'(c) < 32'(cols_eff));
        end
    end

    // B3/S23 over a whole row; cells off the board read as dead and keep their value
    always_comb
    begin
        logic [MAX_COLS-1:0] a;
        logic [MAX_COLS-1:0] h;
        logic [MAX_COLS-1:0] b;
        logic [MAX_COLS-1:0] a_l;
        logic [MAX_COLS-1:0] a_r;
        logic [MAX_COLS-1:0] h_l;
        logic [MAX_COLS-1:0] h_r;
        logic [MAX_COLS-1:0] b_l;
        logic [MAX_COLS-1:0] b_r;
        logic [3:0]          nbr;
        logic                life;
        a   = above_reg & mask_reg;
        h   = here_reg & mask_reg;
        b   = below & mask_reg;
        a_l = a << 1;
        a_r = a >> 1;
        h_l = h << 1;
        h_r = h >> 1;
        b_l = b << 1;
        b_r = b >> 1;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            nbr = 4'(a_l[c]) + 4'(a[c]) + 4'(a_r[c]) + 4'(h_l[c]) + 4'(h_r[c])
                + 4'(b_l[c]) + 4'(b[c]) + 4'(b_r[c]);
            life = (nbr == 4'd3) || ((nbr == 4'd2) && h[c]);
            next_row[c] = mask_reg[c] ? life : here_reg[c];
        end
    end

    // Memory port steering
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = row_cnt_reg;
        wr_data = '0;
        if (dp_cmd.rmw_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = ROW_W'(item_reg.row);
        end
        else if (dp_cmd.adv_p0)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        else if (dp_cmd.adv_p1)
        begin
            rd_en   = 1'b1;
            rd_addr = ROW_W'(1);
        end
        else if (dp_cmd.adv_row)
        begin
            rd_en   = row_p2 < ROW_SUM_W'(rows_eff);
            rd_addr = ROW_W'(row_p2);
        end

        if (dp_cmd.clear_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = row_cnt_reg;
            wr_data = '0;
        end
        else if (dp_cmd.rmw_upd)
        begin
            wr_en   = is_toggle;
            wr_addr = ROW_W'(item_reg.row);
            wr_data = rd_data_reg ^ (MAX_COLS'(1) << col_idx);
        end
        else if (dp_cmd.adv_row)
        begin
            wr_en   = 1'b1;
            wr_addr = row_cnt_reg;
            wr_data = next_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    // Sweep window and item hold
    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            item_reg <= cmd;
        end
        if (dp_cmd.adv_p0)
        begin
            above_reg <= '0;
            mask_reg  <= mask_calc;
        end
        if (dp_cmd.adv_p1)
        begin
            here_reg <= rd_data_reg;
        end
        if (dp_cmd.adv_row)
        begin
            above_reg <= here_reg;
            here_reg  <= below;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            done_reg    <= 1'b0;
            alive_reg   <= 1'b0;
            oor_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= dp_cmd.finish;
            if (dp_cmd.accept)
            begin
                row_cnt_reg <= '0;
                alive_reg   <= 1'b0;
                oor_reg     <= is_rmw_func && !in_range;
            end
            else if (dp_cmd.clear_wr || dp_cmd.adv_row)
            begin
                row_cnt_reg <= row_cnt_reg + ROW_W'(1);
            end
            if (dp_cmd.rmw_upd)
            begin
                alive_reg <= cell_bit;
            end
        end
    end

    assign done             = done_reg;
    assign rsp.cell_alive   = alive_reg;
    assign rsp.out_of_range = oor_reg;

endmodule

// ===== rtl/lgge_checker.sv =====
`timescale 1ns / 1ps

module lgge_checker
    import lgge_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input cmd_t cmd,
    input logic done
);

    // An accepted item keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low after accept");

    // Results never come back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held two cycles");

    // A result only shows once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // The unused operation goes straight to the finish state and still gives a result
    a_nop_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.func == FUNC_UNUSED) |-> ##2 done)
        else $error("no result for unused operation");

endmodule

bind life_grid_generation_engine lgge_checker u_lgge_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lgge_pkg::*;

    typedef bit [MAX_COLS-1:0] grid_row_t;

    // ---------------------------------------------------------------
    // Clock, reset, DUT ports
    // ---------------------------------------------------------------
    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    cmd_t               cmd     = '0;
    logic               busy;
    logic               done;
    rsp_t               rsp;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    always #5 clk = ~clk;

    life_grid_generation_engine uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ---------------------------------------------------------------
    // Shadow state: our own copy of the grid and the board size.
    // Bit c of a row vector is column c.
    // ---------------------------------------------------------------
    grid_row_t               life_grid [MAX_ROWS];
    logic [BOARD_COLS_W-1:0] cols_cfg = 11'd800;
    logic [BOARD_ROWS_W-1:0] rows_cfg = 10'd400;

    cmd_t cmd_backlog [$];       // items waiting to be driven
    rsp_t pending_results [$];   // predicted results, oldest first

    bit   steady = 1'b0;         // no gaps between items in this phase
    int   gap_left = 0;
    int   mismatches = 0;
    int   n_toggle = 0, n_advance = 0, n_read = 0, n_other = 0, n_oor = 0;
    int   boards_tried = 1;

    int   sweep_cols [11];
    int   sweep_rows [11];

    // Registers larger than the grid are clamped to the grid.
    function automatic int live_cols();
        return (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
    endfunction

    function automatic int live_rows();
        return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    endfunction

    // Applies one command to the shadow grid and returns the result the
    // block must produce for it.
    function automatic rsp_t life_step(cmd_t c);
        rsp_t      r;
        int        ec, er;
        grid_row_t mask, above, here, below, nxt;
        grid_row_t s0, s1, s2, s3, c0, c1;
        grid_row_t taps [8];
        r  = '0;
        ec = live_cols();
        er = live_rows();
        if (c.func == FUNC_ADVANCE)
        begin
            // Only columns inside the board take part; cells outside are
            // read as dead and keep their value.
            mask  = (ec >= MAX_COLS) ? '1 : ((grid_row_t'(1) << ec) - grid_row_t'(1));
            above = '0;
            for (int y = 0; y < er; y++)
            begin
                here  = life_grid[y] & mask;
                below = (y + 1 < er) ? (life_grid[y + 1] & mask) : grid_row_t'(0);
                taps  = '{above << 1, above, above >> 1, here << 1, here >> 1,
                          below << 1, below, below >> 1};
                // Per-column neighbour count as a 4-bit bit-sliced counter.
                s0 = '0; s1 = '0; s2 = '0; s3 = '0;
                foreach (taps[k])
                begin
                    c0 = s0 & taps[k];
                    s0 = s0 ^ taps[k];
                    c1 = s1 & c0;
                    s1 = s1 ^ c0;
                    s3 = s3 | (s2 & c1);
                    s2 = s2 ^ c1;
                end
                // born on 3, survives on 2 or 3
                nxt = ~s3 & ~s2 & s1 & (s0 | here);
                life_grid[y] = (life_grid[y] & ~mask) | (nxt & mask);
                above = here;   // unmodified row for the next line
            end
        end
        else if (c.func == FUNC_TOGGLE || c.func == FUNC_READ)
        begin
            if (c.col >= ec || c.row >= er)
                r.out_of_range = 1'b1;
            else
            begin
                if (c.func == FUNC_TOGGLE)
                    life_grid[c.row][c.col] = ~life_grid[c.row][c.col];
                r.cell_alive = life_grid[c.row][c.col];
            end
        end
        return r;
    endfunction

    // Coordinate along one axis: near the low end, near the high end, or
    // anywhere, so corners and borders see plenty of live cells.
    function automatic int axis_pick(int span);
        int w;
        w = (span < 4) ? span : 4;
        case ($urandom_range(0, 2))
            0:       return int'($urandom_range(0, w - 1));
            1:       return span - 1 - int'($urandom_range(0, w - 1));
            default: return int'($urandom_range(0, span - 1));
        endcase
    endfunction

    // Command addressed inside the current board (anywhere if it is empty).
    function automatic cmd_t board_cmd(logic [FUNC_FW-1:0] f);
        cmd_t c;
        int   ec, er;
        ec     = live_cols();
        er     = live_rows();
        c.func = f;
        if (ec == 0 || er == 0)
        begin
            c.col = COL_FW'($urandom_range(0, 1023));
            c.row = ROW_FW'($urandom_range(0, 511));
        end
        else
        begin
            c.col = COL_FW'(axis_pick(ec));
            c.row = ROW_FW'(axis_pick(er));
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (mismatches < 10)
            $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $time);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Driver: one item at a time from cmd_backlog. An item is taken at
    // the edge where start is high and busy low; the prediction is made
    // right there, in acceptance order. An idle gap drawn at random with
    // each item follows its acceptance; steady phases draw no gap.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        rsp_t predicted;
        if (!rst_n)
        begin
            start    <= 1'b0;
            cmd      <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predicted = life_step(cmd);
                pending_results = {pending_results, predicted};
                case (cmd.func)
                    FUNC_TOGGLE:  n_toggle++;
                    FUNC_ADVANCE: n_advance++;
                    FUNC_READ:    n_read++;
                    default:      n_other++;
                endcase
                if (predicted.out_of_range)
                    n_oor++;
            end
            // hold the item while the block is busy
            if (!start || !busy)
            begin
                if (gap_left != 0)
                begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cmd      <= cmd_backlog.pop_front();
                    start    <= 1'b1;
                    gap_left <= steady ? 0 : int'($urandom_range(0, 9));
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: a result is valid for the single cycle done is high.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no item outstanding", 32'd0, 32'(rsp));
            else
            begin
                want = pending_results.pop_front();
                if (rsp.cell_alive !== want.cell_alive)
                    report_mismatch("cell_alive", 32'(want.cell_alive), 32'(rsp.cell_alive));
                if (rsp.out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", 32'(want.out_of_range),
                                    32'(rsp.out_of_range));
            end
        end
    end

    // ---------------------------------------------------------------
    // Config access: APB write, then read back of the same register.
    // ---------------------------------------------------------------
    task automatic program_reg(input logic [PADDR_W-1:0] addr,
                               input logic [PDATA_W-1:0] data,
                               input logic [PDATA_W-1:0] readback);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);             // write lands here
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== readback)
            report_mismatch("register read back", readback, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Upper data bits are random; the block keeps only the register width.
    task automatic set_board(input int cols, input int rows);
        logic [PDATA_W-1:0] d;
        d = ($urandom & ~32'h7FF) | 32'(cols);
        program_reg({REG_BOARD_COLS, 2'b00}, d, 32'(d[BOARD_COLS_W-1:0]));
        cols_cfg = d[BOARD_COLS_W-1:0];
        d = ($urandom & ~32'h3FF) | 32'(rows);
        program_reg({REG_BOARD_ROWS, 2'b00}, d, 32'(d[BOARD_ROWS_W-1:0]));
        rows_cfg = d[BOARD_ROWS_W-1:0];
        boards_tried++;
    endtask

    task automatic enqueue_cmd(input cmd_t c);
        cmd_backlog = {cmd_backlog, c};
    endtask

    task automatic push_cmd(input logic [FUNC_FW-1:0] f, input int c, input int r);
        enqueue_cmd(cmd_t'{func: f, col: COL_FW'(c), row: ROW_FW'(r)});
    endtask

    // Wait until every item went in and every result came back.
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || start || gap_left != 0
               || pending_results.size() != 0)
            @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int n, roll;
        foreach (life_grid[y])
            life_grid[y] = '0;
        // extremes first, then small boards where patterns interact,
        // with the full grid and a shrink-then-grow in between
        sweep_cols = '{1, 2047, 0, 6, 4, 7, 12, 1024, 16, 5, 3};
        sweep_rows = '{1, 1023, 5, 0, 4, 6, 9, 512, 8, 3, 1};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, on the reset board of 800 x 400.
        push_cmd(FUNC_READ,    0,    0);      // dead after reset
        push_cmd(FUNC_TOGGLE,  0,    0);
        push_cmd(FUNC_READ,    0,    0);
        push_cmd(FUNC_TOGGLE,  799,  399);    // far corner, last in range
        push_cmd(FUNC_TOGGLE,  800,  0);      // column just past the board
        push_cmd(FUNC_READ,    0,    400);    // row just past the board
        push_cmd(FUNC_TOGGLE,  1023, 511);    // both fields at max
        push_cmd(FUNC_UNUSED,  1023, 511);
        push_cmd(FUNC_TOGGLE,  10,   10);     // horizontal blinker
        push_cmd(FUNC_TOGGLE,  11,   10);
        push_cmd(FUNC_TOGGLE,  12,   10);
        push_cmd(FUNC_ADVANCE, 0,    0);      // lone corner cells die
        push_cmd(FUNC_READ,    11,   9);
        push_cmd(FUNC_READ,    11,   11);
        push_cmd(FUNC_READ,    10,   10);
        push_cmd(FUNC_READ,    0,    0);
        push_cmd(FUNC_READ,    799,  399);
        push_cmd(FUNC_ADVANCE, 1023, 511);
        push_cmd(FUNC_READ,    10,   10);
        push_cmd(FUNC_READ,    11,   9);
        wait_idle();

        // Random phases, one board size each. Every phase opens with a
        // few toggles on the board so advances have something to evolve.
        for (int p = 0; p < 11; p++)
        begin
            set_board(sweep_cols[p], sweep_rows[p]);
            @(negedge clk);
            steady = ($urandom_range(0, 3) == 0);
            n = $urandom_range(7, 11);
            for (int i = 0; i < n; i++)
            begin
                roll = (i < 3) ? 0 : $urandom_range(0, 19);
                if (roll < 8)
                    enqueue_cmd(board_cmd(FUNC_TOGGLE));
                else if (roll < 11)
                    push_cmd(FUNC_ADVANCE, $urandom_range(0, 1023), $urandom_range(0, 511));
                else if (roll < 17)
                    enqueue_cmd(board_cmd(FUNC_READ));
                else
                    push_cmd(FUNC_FW'($urandom_range(0, 3)), $urandom_range(0, 1023),
                             $urandom_range(0, 511));
            end
            wait_idle();
        end

        // let any stray strobe show up before judging
        repeat (10) @(posedge clk);
        $display("%0d items: %0d toggles, %0d advances, %0d reads, %0d unused code",
                 n_toggle + n_advance + n_read + n_other, n_toggle, n_advance, n_read, n_other);
        $display("%0d out-of-range addresses across %0d board sizes, %0d mismatches",
                 n_oor, boards_tried, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (clear pass, full-grid
    // advances, the longest gaps, config traffic).
    initial
    begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lgge_pkg.sv
rtl/lgge_cfg.sv
rtl/lgge_ctrl.sv
rtl/lgge_datapath.sv
rtl/life_grid_generation_engine.sv
rtl/lgge_checker.sv
bench/tb.sv
